// ===== sv/page_frame_allocator_assert.svh =====
// Assertion macros for the page frame allocator checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_ASSERT_SVH

// Checked at every edge outside reset.
`define PFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define PFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/pfa_pkg.sv =====
// Shared types and constants of the page frame allocator.
// No dependencies.
`default_nettype none

package pfa_pkg;

  localparam int unsigned NumFrames   = 64;
  localparam int unsigned OwnerBits   = 16;
  localparam int unsigned IdxW        = $clog2(NumFrames);
  localparam int unsigned CntW        = $clog2(NumFrames + 1);
  localparam int unsigned NeedW       = CntW + 1;
  localparam int unsigned ReqW        = 32;
  localparam int unsigned PsW         = 16;
  localparam int unsigned OwnerW      = 16;
  localparam int unsigned OutFreeW    = 7;
  localparam logic [PsW-1:0] PageSizeRst = 16'd4096;

  typedef enum logic {
    CmdAlloc   = 1'b0,
    CmdRelease = 1'b1
  } cmd_e;

  typedef enum logic {
    StatDone   = 1'b0,
    StatReject = 1'b1
  } status_e;

  typedef struct packed {
    logic              command;
    logic [OwnerW-1:0] owner_id;
    logic [ReqW-1:0]   request_bytes;
  } in_t;

  typedef struct packed {
    logic                status;
    logic [OutFreeW-1:0] free_frames;
  } out_t;

  // Classified command handed from front to back.
  typedef struct packed {
    logic                 command;
    logic [OwnerBits-1:0] owner;
    logic [NeedW-1:0]     need;
  } work_t;

endpackage

`default_nettype wire

// ===== sv/pfa_front.sv =====
// Front end: takes commands, holds the page size register and works out the
// pages needed with a bit-serial divider. Depends on pfa_pkg.
`default_nettype none

module pfa_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire pfa_pkg::in_t               item_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [pfa_pkg::PsW-1:0]    cfg_wdata_i,
  output logic                            work_valid_o,
  input  wire logic                       work_ready_i,
  output pfa_pkg::work_t                  work_o
);

  localparam int unsigned StepW = $clog2(pfa_pkg::ReqW);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StPush
  } state_e;

  state_e                            state_q, state_d;
  logic [pfa_pkg::PsW-1:0]           page_size_q, page_size_d;
  logic [pfa_pkg::PsW-1:0]           dvs_q, dvs_d;
  logic [pfa_pkg::ReqW-1:0]          quo_q, quo_d;
  logic [pfa_pkg::PsW:0]             rem_q, rem_d;
  logic [StepW-1:0]                  step_q, step_d;
  logic                              cmd_q, cmd_d;
  logic [pfa_pkg::OwnerBits-1:0]     owner_q, owner_d;

  logic [pfa_pkg::PsW:0]             rem_sh;
  logic                              rem_ge;
  logic                              q_hi;
  logic [pfa_pkg::NeedW:0]           need_sum;
  logic [pfa_pkg::NeedW-1:0]         need;

  assign rem_sh = {rem_q[pfa_pkg::PsW-1:0], quo_q[pfa_pkg::ReqW-1]};
  assign rem_ge = (rem_sh >= {1'b0, dvs_q});

  // Ceiling: quotient plus one when a remainder is left; saturate large needs.
  assign q_hi     = |quo_q[pfa_pkg::ReqW-1:pfa_pkg::NeedW];
  assign need_sum = {1'b0, quo_q[pfa_pkg::NeedW-1:0]} + {{pfa_pkg::NeedW{1'b0}}, (rem_q != '0)};
  assign need     = (q_hi || need_sum[pfa_pkg::NeedW]) ? '1 : need_sum[pfa_pkg::NeedW-1:0];

  always_comb begin
    state_d     = state_q;
    page_size_d = page_size_q;
    dvs_d       = dvs_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    step_d      = step_q;
    cmd_d       = cmd_q;
    owner_d     = owner_q;

    if (cfg_we_i) begin
      page_size_d = cfg_wdata_i;
    end

    case (state_q)
      StIdle: begin
        if (push) begin
          cmd_d   = item_i.command;
          owner_d = item_i.owner_id[pfa_pkg::OwnerBits-1:0];
          quo_d   = item_i.request_bytes;
          rem_d   = '0;
          step_d  = '0;
          dvs_d   = (page_size_q == '0) ? pfa_pkg::PsW'(1) : page_size_q;
          if (item_i.command == pfa_pkg::CmdRelease) begin
            // release needs no page count; zero the quotient
            quo_d   = '0;
            state_d = StPush;
          end else begin
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        quo_d  = {quo_q[pfa_pkg::ReqW-2:0], rem_ge};
        rem_d  = rem_ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(pfa_pkg::ReqW - 1)) begin
          state_d = StPush;
        end
      end
      StPush: begin
        if (work_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      page_size_q <= pfa_pkg::PageSizeRst;
      dvs_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      step_q      <= '0;
      cmd_q       <= 1'b0;
      owner_q     <= '0;
    end else begin
      state_q     <= state_d;
      page_size_q <= page_size_d;
      dvs_q       <= dvs_d;
      quo_q       <= quo_d;
      rem_q       <= rem_d;
      step_q      <= step_d;
      cmd_q       <= cmd_d;
      owner_q     <= owner_d;
    end
  end

  assign full         = (state_q != StIdle);
  assign work_valid_o = (state_q == StPush);
  assign work_o       = '{command: cmd_q, owner: owner_q, need: need};

endmodule

`default_nettype wire

// ===== sv/pfa_work_q.sv =====
// Two-entry queue of classified commands between front and back.
// Depends on pfa_pkg.
`default_nettype none

module pfa_work_q (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  output logic                wr_ready_o,
  input  wire pfa_pkg::work_t wr_data_i,
  output logic                rd_valid_o,
  input  wire logic           rd_ready_i,
  output pfa_pkg::work_t      rd_data_o
);

  pfa_pkg::work_t ent_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           do_wr, do_rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = ent_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      ent_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

`default_nettype wire

// ===== sv/pfa_back.sv =====
// Back end: owns the frame table and free count, walks the frames for a
// release or an allocate that fits and holds the result. Depends on pfa_pkg.
`default_nettype none

module pfa_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           work_valid_i,
  output logic                work_ready_o,
  input  wire pfa_pkg::work_t work_i,
  output logic                res_valid_o,
  input  wire logic           res_pop_i,
  output pfa_pkg::out_t       res_o
);

  localparam int unsigned IdxW = pfa_pkg::IdxW;
  localparam logic [IdxW:0] WalkEnd = (IdxW + 1)'(pfa_pkg::NumFrames);

  typedef enum logic [1:0] {
    StIdle,
    StAlloc,
    StRel,
    StOut
  } state_e;

  state_e                          state_q, state_d;
  logic [pfa_pkg::NumFrames-1:0]   used_q, used_d;
  logic [pfa_pkg::CntW-1:0]        free_q, free_d;
  logic [IdxW:0]                   idx_q, idx_d;
  logic                            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]                 cmp_idx_q, cmp_idx_d;
  logic [pfa_pkg::OwnerBits-1:0]   owner_q, owner_d;
  logic [pfa_pkg::NeedW-1:0]       need_q, need_d;
  logic                            status_q, status_d;
  logic                            res_vld_q, res_vld_d;
  pfa_pkg::out_t                   res_q, res_d;

  // Owner table: only meaningful where the used flag is set.
  logic [pfa_pkg::OwnerBits-1:0]   mem [pfa_pkg::NumFrames];
  logic [pfa_pkg::OwnerBits-1:0]   rdata_q;
  logic                            mem_we;
  logic                            res_take;

  assign res_take = res_vld_q && res_pop_i;

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    free_d    = free_q;
    idx_d     = idx_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    owner_d   = owner_q;
    need_d    = need_q;
    status_d  = status_q;
    res_vld_d = res_vld_q && !res_pop_i;
    res_d     = res_q;
    mem_we    = 1'b0;

    case (state_q)
      StIdle: begin
        if (work_valid_i) begin
          owner_d  = work_i.owner;
          need_d   = work_i.need;
          idx_d    = '0;
          status_d = pfa_pkg::StatDone;
          if (work_i.command == pfa_pkg::CmdRelease) begin
            state_d = StRel;
          end else if (work_i.need > {1'b0, free_q}) begin
            status_d = pfa_pkg::StatReject;
            state_d  = StOut;
          end else begin
            state_d = StAlloc;
          end
        end
      end
      StAlloc: begin
        // owner zero ends the walk at once and allocates nothing
        if (owner_q == '0 || need_q == '0 || idx_q == WalkEnd) begin
          state_d = StOut;
        end else begin
          if (!used_q[idx_q[IdxW-1:0]]) begin
            used_d[idx_q[IdxW-1:0]] = 1'b1;
            mem_we = 1'b1;
            free_d = free_q - pfa_pkg::CntW'(1);
            need_d = need_q - pfa_pkg::NeedW'(1);
          end
          idx_d = idx_q + (IdxW + 1)'(1);
        end
      end
      StRel: begin
        // read one frame per cycle, compare it the cycle after
        if (idx_q != WalkEnd) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[IdxW-1:0];
          idx_d     = idx_q + (IdxW + 1)'(1);
        end else if (!cmp_vld_q) begin
          state_d = StOut;
        end
        if (cmp_vld_q && used_q[cmp_idx_q] && rdata_q == owner_q) begin
          used_d[cmp_idx_q] = 1'b0;
          free_d = free_q + pfa_pkg::CntW'(1);
        end
      end
      StOut: begin
        if (!res_vld_q || res_take) begin
          res_d     = '{status: status_q, free_frames: pfa_pkg::OutFreeW'(free_q)};
          res_vld_d = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[idx_q[IdxW-1:0]] <= owner_q;
    end
    rdata_q <= mem[idx_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      used_q    <= '0;
      free_q    <= pfa_pkg::CntW'(pfa_pkg::NumFrames);
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      owner_q   <= '0;
      need_q    <= '0;
      status_q  <= 1'b0;
      res_vld_q <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      free_q    <= free_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      cmp_idx_q <= cmp_idx_d;
      owner_q   <= owner_d;
      need_q    <= need_d;
      status_q  <= status_d;
      res_vld_q <= res_vld_d;
      res_q     <= res_d;
    end
  end

  assign work_ready_o = (state_q == StIdle);
  assign res_valid_o  = res_vld_q;
  assign res_o        = res_q;

endmodule

`default_nettype wire

// ===== sv/page_frame_allocator.sv =====
// Page frame allocator: keeps an owner id for each of 64 page frames and
// answers allocate and release commands with a status and the free count.
// A command enters the front end, which works out the page count of an
// allocate with a one-bit-per-cycle 32-step division and passes a release
// straight on, then waits in a two-entry queue. The back end walks the frame
// table one frame a cycle for a release or an allocate that fits, posts the
// result and takes the next command; that walk sets the sustained rate, and
// front and back overlap on consecutive commands. One result is held while
// the back end works on the next command. Reset frees every frame at once
// through per-frame used flags; no clearing pass is needed.
// Write the page size register only while the block is idle.
`default_nettype none

module page_frame_allocator (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push,
  output logic                         full,
  input  wire pfa_pkg::in_t            item_i,
  output logic                         empty,
  input  wire logic                    pop,
  output pfa_pkg::out_t                result_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [pfa_pkg::PsW-1:0] cfg_wdata_i
);

  logic           fw_valid, fw_ready;
  pfa_pkg::work_t fw_data;
  logic           wb_valid, wb_ready;
  pfa_pkg::work_t wb_data;
  logic           res_valid;

  pfa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .item_i       (item_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .work_valid_o (fw_valid),
    .work_ready_i (fw_ready),
    .work_o       (fw_data)
  );

  pfa_work_q u_work_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fw_valid),
    .wr_ready_o (fw_ready),
    .wr_data_i  (fw_data),
    .rd_valid_o (wb_valid),
    .rd_ready_i (wb_ready),
    .rd_data_o  (wb_data)
  );

  pfa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (wb_valid),
    .work_ready_o (wb_ready),
    .work_i       (wb_data),
    .res_valid_o  (res_valid),
    .res_pop_i    (pop),
    .res_o        (result_o)
  );

  assign empty = !res_valid;

endmodule

`default_nettype wire

// ===== sv/pfa_checker.sv =====
// Port-level checks for the page frame allocator, bound to the top level.
// Depends on pfa_pkg and page_frame_allocator_assert.svh.
`default_nettype none

`include "page_frame_allocator_assert.svh"

module pfa_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          push,
  input wire logic          full,
  input wire logic          empty,
  input wire logic          pop,
  input wire pfa_pkg::out_t result_o
);

  // Commands taken but not yet delivered.
  logic [3:0] inflight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + {3'd0, (push && !full)} - {3'd0, (pop && !empty)};
    end
  end

  // Reset clears the result register, so the edge after reset is seen shows no beat.
  `PFA_ASSERT_ALWAYS(a_empty_in_reset, !rst_ni |=> empty, "result shown during reset")
  `PFA_ASSERT(a_free_in_range, !empty |-> (result_o.free_frames <= 7'(pfa_pkg::NumFrames)), "free count exceeds frame count")
  `PFA_ASSERT(a_no_invented_beat, !empty |-> (inflight_q != 4'd0), "result without a command")
  `PFA_ASSERT(a_result_holds, (!empty && !pop) |=> (!empty && $stable(result_o)), "stalled result changed")

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

`default_nettype wire
